[sv/rv32ie_pkg.sv]
// Shared types, opcode codes and pipeline constants for the RV32IM execute unit.
// Used by every module of the block; depends on nothing else.
package rv32ie_pkg;

    localparam int XLEN      = 32;
    localparam int EX_STAGES = 32;  // divider steps, one quotient bit per stage
    localparam int MUL_STAGES = 3;  // partial products, sum, sign correction

    // Dense opcode codes.
    localparam logic [5:0] OP_ADD    = 6'd0;
    localparam logic [5:0] OP_SUB    = 6'd1;
    localparam logic [5:0] OP_XOR    = 6'd2;
    localparam logic [5:0] OP_OR     = 6'd3;
    localparam logic [5:0] OP_AND    = 6'd4;
    localparam logic [5:0] OP_SLL    = 6'd5;
    localparam logic [5:0] OP_SLT    = 6'd6;
    localparam logic [5:0] OP_SLTU   = 6'd7;
    localparam logic [5:0] OP_SRL    = 6'd8;
    localparam logic [5:0] OP_SRA    = 6'd9;
    localparam logic [5:0] OP_ADDI   = 6'd10;
    localparam logic [5:0] OP_XORI   = 6'd11;
    localparam logic [5:0] OP_ORI    = 6'd12;
    localparam logic [5:0] OP_ANDI   = 6'd13;
    localparam logic [5:0] OP_SLLI   = 6'd14;
    localparam logic [5:0] OP_SRLI   = 6'd15;
    localparam logic [5:0] OP_SRAI   = 6'd16;
    localparam logic [5:0] OP_SLTI   = 6'd17;
    localparam logic [5:0] OP_SLTIU  = 6'd18;
    localparam logic [5:0] OP_BEQ    = 6'd19;
    localparam logic [5:0] OP_BNE    = 6'd20;
    localparam logic [5:0] OP_BLT    = 6'd21;
    localparam logic [5:0] OP_BGE    = 6'd22;
    localparam logic [5:0] OP_BLTU   = 6'd23;
    localparam logic [5:0] OP_BGEU   = 6'd24;
    localparam logic [5:0] OP_JAL    = 6'd25;
    localparam logic [5:0] OP_JALR   = 6'd26;
    localparam logic [5:0] OP_LUI    = 6'd27;
    localparam logic [5:0] OP_AUIPC  = 6'd28;
    localparam logic [5:0] OP_MUL    = 6'd29;
    localparam logic [5:0] OP_MULH   = 6'd30;
    localparam logic [5:0] OP_MULHSU = 6'd31;
    localparam logic [5:0] OP_MULHU  = 6'd32;
    localparam logic [5:0] OP_DIV    = 6'd33;
    localparam logic [5:0] OP_DIVU   = 6'd34;
    localparam logic [5:0] OP_REM    = 6'd35;
    localparam logic [5:0] OP_REMU   = 6'd36;

    // Which unit supplies the destination value.
    typedef enum logic [1:0] {
        SEL_ALU,
        SEL_MUL,
        SEL_DIV
    } res_sel_t;

    // Everything that travels beside the multiplier and divider.
    typedef struct packed {
        logic [XLEN-1:0] alu_res;
        logic            writes;
        logic            taken;
        logic [XLEN-1:0] target;
        logic [4:0]      rd;
        res_sel_t        sel;
    } side_t;

    typedef struct packed {
        logic hi;
        logic a_sgn;
        logic b_sgn;
    } mul_ctl_t;

    typedef struct packed {
        logic sgn;
        logic is_rem;
    } div_ctl_t;

endpackage

[sv/rv32ie_alu.sv]
// Decoder, combinational ALU and branch unit of the RV32IM execute unit.
// Depends on rv32ie_pkg.
module rv32ie_alu (
    input  logic [5:0]                 op,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    input  logic [31:0]                imm,
    input  logic [31:0]                pc,
    input  logic [4:0]                 rd,
    output rv32ie_pkg::side_t          side,
    output rv32ie_pkg::mul_ctl_t       mul_ctl,
    output rv32ie_pkg::div_ctl_t       div_ctl
);
    import rv32ie_pkg::*;

    logic        lt_s_b, lt_u_b, lt_s_i, lt_u_i, eq_b;
    logic [31:0] sum_b, sum_i, sum_pc, diff_b;

    // Shared compares and adders.
    assign lt_s_b = $signed(a) < $signed(b);
    assign lt_u_b = a < b;
    assign lt_s_i = $signed(a) < $signed(imm);
    assign lt_u_i = a < imm;
    assign eq_b   = a == b;
    assign sum_b  = a + b;
    assign diff_b = a - b;
    assign sum_i  = a + imm;
    assign sum_pc = pc + imm;

    // Operation decode and result selection.
    always_comb begin
        side.alu_res = '0;
        side.writes  = 1'b1;
        side.taken   = 1'b0;
        side.target  = '0;
        side.rd      = rd;
        side.sel     = SEL_ALU;
        mul_ctl      = '0;
        div_ctl      = '0;
        unique case (op)
            OP_ADD:   side.alu_res = sum_b;
            OP_SUB:   side.alu_res = diff_b;
            OP_XOR:   side.alu_res = a ^ b;
            OP_OR:    side.alu_res = a | b;
            OP_AND:   side.alu_res = a & b;
            OP_SLL:   side.alu_res = a << b[4:0];
            OP_SLT:   side.alu_res = {31'b0, lt_s_b};
            OP_SLTU:  side.alu_res = {31'b0, lt_u_b};
            OP_SRL:   side.alu_res = a >> b[4:0];
            OP_SRA:   side.alu_res = 32'($signed(a) >>> b[4:0]);
            OP_ADDI:  side.alu_res = sum_i;
            OP_XORI:  side.alu_res = a ^ imm;
            OP_ORI:   side.alu_res = a | imm;
            OP_ANDI:  side.alu_res = a & imm;
            OP_SLLI:  side.alu_res = a << imm[4:0];
            OP_SRLI:  side.alu_res = a >> imm[4:0];
            OP_SRAI:  side.alu_res = 32'($signed(a) >>> imm[4:0]);
            OP_SLTI:  side.alu_res = {31'b0, lt_s_i};
            OP_SLTIU: side.alu_res = {31'b0, lt_u_i};
            OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
                side.writes = 1'b0;
                unique case (op)
                    OP_BEQ:  side.taken = eq_b;
                    OP_BNE:  side.taken = !eq_b;
                    OP_BLT:  side.taken = lt_s_b;
                    OP_BGE:  side.taken = !lt_s_b;
                    OP_BLTU: side.taken = lt_u_b;
                    default: side.taken = !lt_u_b;
                endcase
                side.target = side.taken ? sum_pc : '0;
            end
            OP_JAL: begin
                side.taken   = 1'b1;
                side.target  = sum_pc;
                side.alu_res = pc + 32'd4;
            end
            OP_JALR: begin
                side.taken   = 1'b1;
                side.target  = {sum_i[31:1], 1'b0};
                side.alu_res = pc + 32'd4;
            end
            OP_LUI:   side.alu_res = imm;
            OP_AUIPC: side.alu_res = sum_pc;
            OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: begin
                side.sel      = SEL_MUL;
                mul_ctl.hi    = op != OP_MUL;
                mul_ctl.a_sgn = (op == OP_MULH) || (op == OP_MULHSU);
                mul_ctl.b_sgn = op == OP_MULH;
            end
            OP_DIV, OP_DIVU, OP_REM, OP_REMU: begin
                side.sel       = SEL_DIV;
                div_ctl.sgn    = (op == OP_DIV) || (op == OP_REM);
                div_ctl.is_rem = (op == OP_REM) || (op == OP_REMU);
            end
            default: side.writes = 1'b0;
        endcase
    end

endmodule

[sv/rv32ie_mul.sv]
// Pipelined 32x32 multiplier with high-word sign correction, padded to the
// execute pipeline depth. Depends on rv32ie_pkg.
module rv32ie_mul (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    input  rv32ie_pkg::mul_ctl_t       ctl,
    output logic [31:0]                result
);
    import rv32ie_pkg::*;

    localparam int PAD = EX_STAGES - MUL_STAGES;

    logic [47:0] pp_lo_reg, pp_hi_reg;
    logic [31:0] a1_reg, b1_reg, a2_reg, b2_reg;
    mul_ctl_t    ctl1_reg, ctl2_reg;
    logic [63:0] prod_reg;
    logic [31:0] res_reg;
    logic [31:0] pad_reg [0:PAD-1];
    logic [31:0] corr_a, corr_b;

    // Stage one: two 32x16 partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            pp_lo_reg <= 48'(a) * 48'(b[15:0]);
            pp_hi_reg <= 48'(a) * 48'(b[31:16]);
            a1_reg    <= a;
            b1_reg    <= b;
            ctl1_reg  <= ctl;
        end
    end

    // Stage two: sum of the partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= {16'b0, pp_lo_reg} + {pp_hi_reg, 16'b0};
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Stage three: signed high words subtract the other operand per negative sign.
    assign corr_a = (ctl2_reg.a_sgn && a2_reg[31]) ? b2_reg : '0;
    assign corr_b = (ctl2_reg.b_sgn && b2_reg[31]) ? a2_reg : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= ctl2_reg.hi ? (prod_reg[63:32] - corr_a - corr_b) : prod_reg[31:0];
        end
    end

    // Delay line that matches the divider latency.
    always_ff @(posedge aclk) begin
        if (en) begin
            pad_reg[0] <= res_reg;
            for (int i = 1; i < PAD; i++) begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign result = pad_reg[PAD-1];

endmodule

[sv/rv32ie_div.sv]
// Fully pipelined restoring divider, one quotient bit per stage, with the
// RISC-V rules for a zero divisor and signed results. Depends on rv32ie_pkg.
module rv32ie_div (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [31:0]                a,
    input  logic [31:0]                b,
    input  rv32ie_pkg::div_ctl_t       ctl,
    output logic [31:0]                result
);
    import rv32ie_pkg::*;

    typedef struct packed {
        logic        is_rem;
        logic        neg_q;
        logic        neg_r;
        logic        zero;
        logic [31:0] a_orig;
    } dstage_t;

    logic [31:0] rem_reg [0:EX_STAGES-1];
    logic [31:0] quo_reg [0:EX_STAGES-1];
    logic [31:0] dvs_reg [0:EX_STAGES-1];
    dstage_t     dctl_reg [0:EX_STAGES-1];

    logic [31:0] a_mag, b_mag;
    dstage_t     dctl_in;
    logic [31:0] q_fin, r_fin;

    // Operand magnitudes and sign bookkeeping.
    assign a_mag = (ctl.sgn && a[31]) ? (32'd0 - a) : a;
    assign b_mag = (ctl.sgn && b[31]) ? (32'd0 - b) : b;
    assign dctl_in.is_rem = ctl.is_rem;
    assign dctl_in.neg_q  = ctl.sgn && (a[31] ^ b[31]);
    assign dctl_in.neg_r  = ctl.sgn && a[31];
    assign dctl_in.zero   = b == 32'd0;
    assign dctl_in.a_orig = a;

    // One trial subtraction per stage.
    for (genvar i = 0; i < EX_STAGES; i++) begin : g_step
        logic [31:0] rem_in, quo_in, dvs_in;
        dstage_t     dctl_in_s;
        logic [32:0] trial;
        logic [33:0] diff;
        logic        ge;

        if (i == 0) begin : g_first
            assign rem_in    = '0;
            assign quo_in    = a_mag;
            assign dvs_in    = b_mag;
            assign dctl_in_s = dctl_in;
        end else begin : g_next
            assign rem_in    = rem_reg[i-1];
            assign quo_in    = quo_reg[i-1];
            assign dvs_in    = dvs_reg[i-1];
            assign dctl_in_s = dctl_reg[i-1];
        end

        assign trial = {rem_in, quo_in[31]};
        assign diff  = {1'b0, trial} - {2'b0, dvs_in};
        assign ge    = !diff[33];

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? diff[31:0] : trial[31:0];
                quo_reg[i]  <= {quo_in[30:0], ge};
                dvs_reg[i]  <= dvs_in;
                dctl_reg[i] <= dctl_in_s;
            end
        end
    end

    // Final sign fix and special cases.
    assign q_fin = quo_reg[EX_STAGES-1];
    assign r_fin = rem_reg[EX_STAGES-1];

    always_comb begin
        priority if (dctl_reg[EX_STAGES-1].zero) begin
            result = dctl_reg[EX_STAGES-1].is_rem ? dctl_reg[EX_STAGES-1].a_orig : '1;
        end else if (dctl_reg[EX_STAGES-1].is_rem) begin
            result = dctl_reg[EX_STAGES-1].neg_r ? (32'd0 - r_fin) : r_fin;
        end else begin
            result = dctl_reg[EX_STAGES-1].neg_q ? (32'd0 - q_fin) : q_fin;
        end
    end

endmodule

[sv/rv32im_integer_execute_unit.sv]
// Top level of the RV32IM execute unit: input register, ALU, pipelined
// multiplier and divider, result register. Depends on rv32ie_pkg and all rv32ie_ modules.
//
//  Channel  | Direction | Payload (tdata, lowest bit first)
//  ---------+-----------+----------------------------------------------------
//  s_axis   | in        | op, src_a, src_b, imm, pc, dest_reg (144 bits)
//  m_axis   | out       | result, write_enable, dest_out, redirect, target_pc (72)
//
// Every word passes from acceptance to output through one input register,
// 32 divider stages that set the depth for all operations, and one result register.
// A new word is accepted every cycle while the output is free or taken.
// Reset clears all valid bits; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; nothing is dropped or repeated.
module rv32im_integer_execute_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // op, src_a, src_b, imm, pc, dest_reg, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // result, write_enable, dest_out, redirect, target_pc, pad
);
    import rv32ie_pkg::*;

    logic        adv;
    logic        v0_reg;
    logic [5:0]  op_reg;
    logic [31:0] a_reg, b_reg, imm_reg, pc_reg;
    logic [4:0]  rd_reg;

    side_t       side;
    mul_ctl_t    mul_ctl;
    div_ctl_t    div_ctl;
    side_t       side_reg [0:EX_STAGES-1];
    logic        vp_reg   [0:EX_STAGES-1];
    logic [31:0] mul_res, div_res, fin_res;
    side_t       side_last;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg  <= s_tdata[5:0];
            a_reg   <= s_tdata[37:6];
            b_reg   <= s_tdata[69:38];
            imm_reg <= s_tdata[101:70];
            pc_reg  <= s_tdata[133:102];
            rd_reg  <= s_tdata[138:134];
        end
    end

    rv32ie_alu u_alu (
        .op      (op_reg),
        .a       (a_reg),
        .b       (b_reg),
        .imm     (imm_reg),
        .pc      (pc_reg),
        .rd      (rd_reg),
        .side    (side),
        .mul_ctl (mul_ctl),
        .div_ctl (div_ctl)
    );

    rv32ie_mul u_mul (
        .aclk   (aclk),
        .en     (adv),
        .a      (a_reg),
        .b      (b_reg),
        .ctl    (mul_ctl),
        .result (mul_res)
    );

    rv32ie_div u_div (
        .aclk   (aclk),
        .en     (adv),
        .a      (a_reg),
        .b      (b_reg),
        .ctl    (div_ctl),
        .result (div_res)
    );

    // Valid bits alongside the arithmetic stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < EX_STAGES; i++) begin
                vp_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vp_reg[0] <= v0_reg;
            for (int i = 1; i < EX_STAGES; i++) begin
                vp_reg[i] <= vp_reg[i-1];
            end
        end
    end

    // ALU results, branch outcome and destination alongside the arithmetic stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side;
            for (int i = 1; i < EX_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign side_last = side_reg[EX_STAGES-1];

    // Result selection.
    always_comb begin
        unique case (side_last.sel)
            SEL_MUL: fin_res = mul_res;
            SEL_DIV: fin_res = div_res;
            default: fin_res = side_last.alu_res;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= vp_reg[EX_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= {1'b0,
                            side_last.target,
                            side_last.taken,
                            side_last.rd,
                            side_last.writes && (side_last.rd != 5'd0),
                            fin_res};
        end
    end

endmodule
